FILE: rtl/light_scene_fps_selector_unit_defines.svh
`ifndef LIGHT_SCENE_FPS_SELECTOR_UNIT_DEFINES_SVH
`define LIGHT_SCENE_FPS_SELECTOR_UNIT_DEFINES_SVH

// same-cycle implication, masked during reset
`define LSFPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, masked during reset
`define LSFPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/lsfps_pkg.sv
package lsfps_pkg;

	localparam int FPS_W = 8;
	localparam int MS_W  = 16;
	localparam int US_W  = 26;

	localparam logic [9:0]  US_PER_MS   = 10'd1000;
	localparam logic [19:0] RATIO_SCALE = 20'd1000000;

	localparam logic [23:0] FPS_SET_RST      = 24'd3940623;
	localparam logic [19:0] BRIGHT_MAX_RST   = 20'd10000;
	localparam logic [31:0] GAIN_LIMITS_RST  = 32'd268567040;
	localparam logic [31:0] LUMA_LIMITS_RST  = 32'd2621500416;
	localparam logic [15:0] LOW_RATIO_RST    = 16'd58982;
	localparam logic [47:0] CONFIRM_RST      = 48'd0;
	localparam logic [15:0] EVAL_INT_RST     = 16'd1000;
	localparam logic [15:0] MIN_SWITCH_RST   = 16'd5000;

	localparam int CFG_DATA_W = 48;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FPS_SET        = 3'd0,
		REG_BRIGHT_MAX_EXP = 3'd1,
		REG_GAIN_LIMITS    = 3'd2,
		REG_LUMA_LIMITS    = 3'd3,
		REG_LOW_EXP_RATIO  = 3'd4,
		REG_CONFIRM_TIMES  = 3'd5,
		REG_EVAL_INTERVAL  = 3'd6,
		REG_MIN_SWITCH     = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		CLASS_NORMAL = 2'd0,
		CLASS_LOW    = 2'd1,
		CLASS_BRIGHT = 2'd2
	} scene_class_t;

	typedef struct packed {
		logic [23:0] fps_set;
		logic [19:0] bright_max_exposure;
		logic [31:0] gain_limits;
		logic [31:0] luma_limits;
		logic [15:0] low_exposure_ratio;
		logic [47:0] confirm_times;
		logic [15:0] evaluate_interval;
		logic [15:0] min_switch_interval;
	} cfg_t;

	typedef struct packed {
		logic             low;
		logic             bright;
		logic [FPS_W-1:0] target;
		logic [US_W-1:0]  dwell_us;
	} grade_t;

	function automatic logic [US_W-1:0] ms_to_us(input logic [MS_W-1:0] ms);
		ms_to_us = US_W'(ms) * US_W'(US_PER_MS);
	endfunction

endpackage

FILE: rtl/light_scene_fps_selector_unit.sv
// Flow: an accepted tick is written into the queue; the back stage pops it and registers
// its result, which then drives the result beat. Throughput: one tick per cycle while
// result_stall stays low; the back stage updates all its timing state together.
// A two-entry queue parts the grading front from the state back, so each side stalls alone.
// tick_stall rises only when that queue is full; result_stall holds the output register.
// Reset (arst_n low, asynchronous): registers return to defaults, time and rate state
// clears to zero, the queue empties and no result is valid.
module light_scene_fps_selector_unit import lsfps_pkg::*; #(
	parameter int TIME_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic                  tick_valid,
	output logic                  tick_stall,
	input  logic [63:0]           now_us,
	input  logic                  ae_ok,
	input  logic                  exposure_limit_hit,
	input  logic [23:0]           exposure_time,
	input  logic [15:0]           sensor_gain,
	input  logic [15:0]           luma_avg,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [7:0]            frame_rate,
	output logic [1:0]            scene_class,
	output logic                  evaluated,
	output logic                  low_light_seen,
	output logic                  bright_seen,
	output logic                  switched
);

	localparam int QW = TIME_WIDTH + $bits(grade_t);

	cfg_t                  cfg_q;
	grade_t                grade, q_grade;
	logic                  q_full, q_valid, push, pop;
	logic [QW-1:0]         q_out;
	logic [TIME_WIDTH-1:0] q_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fps_set             <= FPS_SET_RST;
			cfg_q.bright_max_exposure <= BRIGHT_MAX_RST;
			cfg_q.gain_limits         <= GAIN_LIMITS_RST;
			cfg_q.luma_limits         <= LUMA_LIMITS_RST;
			cfg_q.low_exposure_ratio  <= LOW_RATIO_RST;
			cfg_q.confirm_times       <= CONFIRM_RST;
			cfg_q.evaluate_interval   <= EVAL_INT_RST;
			cfg_q.min_switch_interval <= MIN_SWITCH_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_FPS_SET:        cfg_q.fps_set             <= wr_data[23:0];
				REG_BRIGHT_MAX_EXP: cfg_q.bright_max_exposure <= wr_data[19:0];
				REG_GAIN_LIMITS:    cfg_q.gain_limits         <= wr_data[31:0];
				REG_LUMA_LIMITS:    cfg_q.luma_limits         <= wr_data[31:0];
				REG_LOW_EXP_RATIO:  cfg_q.low_exposure_ratio  <= wr_data[15:0];
				REG_CONFIRM_TIMES:  cfg_q.confirm_times       <= wr_data[47:0];
				REG_EVAL_INTERVAL:  cfg_q.evaluate_interval   <= wr_data[15:0];
				REG_MIN_SWITCH:     cfg_q.min_switch_interval <= wr_data[15:0];
				default: begin
				end
			endcase
		end
	end

	lsfps_front u_front (
		.cfg                (cfg_q),
		.ae_ok              (ae_ok),
		.exposure_limit_hit (exposure_limit_hit),
		.exposure_time      (exposure_time),
		.sensor_gain        (sensor_gain),
		.luma_avg           (luma_avg),
		.grade              (grade)
	);

	assign tick_stall = q_full;
	assign push       = tick_valid && !q_full;

	lsfps_queue #(
		.W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({now_us[TIME_WIDTH-1:0], grade}),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (q_out),
		.not_empty (q_valid)
	);

	assign q_now   = q_out[QW-1 -: TIME_WIDTH];
	assign q_grade = grade_t'(q_out[$bits(grade_t)-1:0]);

	lsfps_back #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_valid        (q_valid),
		.q_now          (q_now),
		.q_grade        (q_grade),
		.pop            (pop),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.frame_rate     (frame_rate),
		.scene_class    (scene_class),
		.evaluated      (evaluated),
		.low_light_seen (low_light_seen),
		.bright_seen    (bright_seen),
		.switched       (switched)
	);

endmodule

FILE: rtl/lsfps_front.sv
module lsfps_front import lsfps_pkg::*; (
	input  cfg_t        cfg,
	input  logic        ae_ok,
	input  logic        exposure_limit_hit,
	input  logic [23:0] exposure_time,
	input  logic [15:0] sensor_gain,
	input  logic [15:0] luma_avg,
	output grade_t      grade
);

	logic [FPS_W-1:0] low_fps, norm_fps, bright_rate, target;
	logic [31:0]      exp_fps;
	logic [47:0]      lhs;
	logic [35:0]      rhs;
	logic             near, low, bright;
	logic [MS_W-1:0]  confirm_ms;

	assign low_fps     = cfg.fps_set[7:0];
	assign norm_fps    = cfg.fps_set[15:8];
	assign bright_rate = cfg.fps_set[23:16];

	assign exp_fps = 32'(exposure_time) * 32'(norm_fps);
	assign lhs     = {exp_fps, 16'd0};
	assign rhs     = 36'(cfg.low_exposure_ratio) * 36'(RATIO_SCALE);

	assign near = exposure_limit_hit || ((exposure_time != 24'd0) && (lhs >= 48'(rhs)));

	assign low = ae_ok && (norm_fps != '0) && near &&
		(sensor_gain >= cfg.gain_limits[31:16]) && (luma_avg <= cfg.luma_limits[31:16]);

	assign bright = ae_ok && (exposure_time != 24'd0) &&
		(exposure_time <= 24'(cfg.bright_max_exposure)) &&
		(sensor_gain != 16'd0) && (sensor_gain <= cfg.gain_limits[15:0]) &&
		(luma_avg >= cfg.luma_limits[15:0]);

	always_comb begin
		if (!ae_ok) begin
			target = norm_fps;
		end else if (low) begin
			target = low_fps;
		end else if (bright) begin
			target = bright_rate;
		end else begin
			target = norm_fps;
		end
	end

	always_comb begin
		if (target == bright_rate) begin
			confirm_ms = cfg.confirm_times[15:0];
		end else if (target == low_fps) begin
			confirm_ms = cfg.confirm_times[31:16];
		end else begin
			confirm_ms = cfg.confirm_times[47:32];
		end
	end

	assign grade.low      = low;
	assign grade.bright   = bright;
	assign grade.target   = target;
	assign grade.dwell_us = ms_to_us(confirm_ms);

endmodule

FILE: rtl/lsfps_queue.sv
module lsfps_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         not_empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

FILE: rtl/lsfps_back.sv
module lsfps_back import lsfps_pkg::*; #(
	parameter int TIME_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  q_valid,
	input  logic [TIME_WIDTH-1:0] q_now,
	input  grade_t                q_grade,
	output logic                  pop,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [7:0]            frame_rate,
	output logic [1:0]            scene_class,
	output logic                  evaluated,
	output logic                  low_light_seen,
	output logic                  bright_seen,
	output logic                  switched
);

	logic [TIME_WIDTH-1:0] last_eval_q, pending_since_q, last_switch_q;
	logic [FPS_W-1:0]      pending_rate_q, committed_q;
	logic                  result_valid_q;

	logic [TIME_WIDTH-1:0] eval_dt, pend_dt, switch_dt;
	logic [TIME_WIDTH-1:0] interval_us, min_us, dwell_us;
	logic                  skip, commit_ok, new_pending, do_commit, switch_ok;
	logic [FPS_W-1:0]      committed_nx, scene, target;
	scene_class_t          cls;

	logic [7:0] frame_rate_s1;
	logic [1:0] scene_class_s1;
	logic       evaluated_s1, low_s1, bright_s1, switched_s1;

	assign pop = q_valid && (!result_valid_q || !result_stall);

	assign target      = q_grade.target;
	assign interval_us = TIME_WIDTH'(ms_to_us(cfg.evaluate_interval));
	assign min_us      = TIME_WIDTH'(ms_to_us(cfg.min_switch_interval));
	assign dwell_us    = TIME_WIDTH'(q_grade.dwell_us);

	assign eval_dt   = q_now - last_eval_q;
	assign pend_dt   = q_now - pending_since_q;
	assign switch_dt = q_now - last_switch_q;

	assign skip = (last_eval_q != '0) && (eval_dt < interval_us);

	always_comb begin
		new_pending = target != pending_rate_q;
		commit_ok   = !new_pending;
		if (!new_pending && (target != committed_q)) begin
			if ((q_now >= pending_since_q) && (pend_dt < dwell_us)) begin
				commit_ok = 1'b0;
			end
		end
		switch_ok = !((last_switch_q != '0) && (q_now >= last_switch_q)) ||
			(switch_dt >= min_us);
		do_commit = !skip && commit_ok && (target != committed_q) && switch_ok;
	end

	assign committed_nx = do_commit ? target : committed_q;
	assign scene        = (committed_nx != '0) ? committed_nx : cfg.fps_set[15:8];

	always_comb begin
		if (scene == cfg.fps_set[7:0]) begin
			cls = CLASS_LOW;
		end else if (scene == cfg.fps_set[23:16]) begin
			cls = CLASS_BRIGHT;
		end else begin
			cls = CLASS_NORMAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_eval_q     <= '0;
			pending_since_q <= '0;
			last_switch_q   <= '0;
			pending_rate_q  <= '0;
			committed_q     <= '0;
			result_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (pop && !skip) begin
				last_eval_q <= q_now;
				if (new_pending) begin
					pending_rate_q  <= target;
					pending_since_q <= q_now;
				end
				if (do_commit) begin
					committed_q   <= target;
					last_switch_q <= q_now;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			frame_rate_s1  <= scene;
			scene_class_s1 <= cls;
			evaluated_s1   <= !skip;
			low_s1         <= !skip && q_grade.low;
			bright_s1      <= !skip && q_grade.bright;
			switched_s1    <= do_commit;
		end
	end

	assign result_valid   = result_valid_q;
	assign frame_rate     = frame_rate_s1;
	assign scene_class    = scene_class_s1;
	assign evaluated      = evaluated_s1;
	assign low_light_seen = low_s1;
	assign bright_seen    = bright_s1;
	assign switched       = switched_s1;

endmodule

FILE: rtl/lsfps_checker.sv
`include "light_scene_fps_selector_unit_defines.svh"

module lsfps_checker import lsfps_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_stall,
	input logic [7:0] frame_rate,
	input logic [1:0] scene_class,
	input logic       evaluated,
	input logic       low_light_seen,
	input logic       bright_seen,
	input logic       switched
);

	// hold a stalled result beat
	`LSFPS_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(frame_rate) && $stable(scene_class) && $stable(switched), "stalled result beat changed")

	// drop all grade flags on a skipped tick
	`LSFPS_ASSERT_IMP(a_skip_quiet, clk, arst_n, result_valid && !evaluated, !switched && !low_light_seen && !bright_seen, "skipped tick reports activity")

	`LSFPS_ASSERT_IMP(a_class_code, clk, arst_n, result_valid, scene_class == CLASS_NORMAL || scene_class == CLASS_LOW || scene_class == CLASS_BRIGHT, "scene class out of range")

endmodule

bind light_scene_fps_selector_unit lsfps_checker u_lsfps_checker (.*);

FILE: bench/light_scene_fps_selector_unit_test.sv
`timescale 1ns / 100ps

module light_scene_fps_selector_unit_test;
	import lsfps_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [63:0] now_us;
		logic        ae_ok;
		logic        limit_hit;
		logic [23:0] exposure;
		logic [15:0] gain;
		logic [15:0] luma;
	} tick_t;

	typedef struct packed {
		logic [7:0]   fps;
		scene_class_t cls;
		logic         evaluated;
		logic         low_seen;
		logic         bright_seen;
		logic         switched;
	} scene_t;

	typedef enum int {SCENE_LOW, SCENE_BRIGHT, SCENE_PLAIN, SCENE_NOISE, SCENE_BLIND} scene_kind_t;
	typedef enum int {STYLE_ZERO, STYLE_MAX, STYLE_TIGHT} settings_style_t;
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;
	logic                  tick_valid = 1'b0;
	logic                  tick_stall;
	logic [63:0]           now_us = '0;
	logic                  ae_ok = 1'b0;
	logic                  exposure_limit_hit = 1'b0;
	logic [23:0]           exposure_time = '0;
	logic [15:0]           sensor_gain = '0;
	logic [15:0]           luma_avg = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [7:0]            frame_rate;
	logic [1:0]            scene_class;
	logic                  evaluated;
	logic                  low_light_seen;
	logic                  bright_seen;
	logic                  switched;

	light_scene_fps_selector_unit dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.wr_en              (wr_en),
		.wr_index           (wr_index),
		.wr_data            (wr_data),
		.tick_valid         (tick_valid),
		.tick_stall         (tick_stall),
		.now_us             (now_us),
		.ae_ok              (ae_ok),
		.exposure_limit_hit (exposure_limit_hit),
		.exposure_time      (exposure_time),
		.sensor_gain        (sensor_gain),
		.luma_avg           (luma_avg),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.frame_rate         (frame_rate),
		.scene_class        (scene_class),
		.evaluated          (evaluated),
		.low_light_seen     (low_light_seen),
		.bright_seen        (bright_seen),
		.switched           (switched)
	);

	always #6 clk = ~clk;

	// configuration copy
	logic [23:0] cfg_fps_set        = FPS_SET_RST;
	logic [19:0] cfg_bright_max     = BRIGHT_MAX_RST;
	logic [31:0] cfg_gain_limits    = GAIN_LIMITS_RST;
	logic [31:0] cfg_luma_limits    = LUMA_LIMITS_RST;
	logic [15:0] cfg_low_ratio      = LOW_RATIO_RST;
	logic [47:0] cfg_confirm_ms     = CONFIRM_RST;
	logic [15:0] cfg_eval_ms        = EVAL_INT_RST;
	logic [15:0] cfg_min_switch_ms  = MIN_SWITCH_RST;

	// selector state copy
	logic [63:0] seen_eval_us  = '0;
	logic [7:0]  hold_rate     = '0;
	logic [63:0] hold_since_us = '0;
	logic [7:0]  locked_rate   = '0;
	logic [63:0] switch_at_us  = '0;

	scene_t      expected_scene_q[$];
	int          fail_count = 0;
	int unsigned cycle_count = 0;
	logic [63:0] tick_clock_us = '0;
	int unsigned step_max_us = 4000;
	int unsigned burst_left = 0;
	bit          steady_feed = 1'b0;
	int unsigned hold_request = 0;
	int unsigned hold_left = 0;
	int unsigned mode_left = 0;
	stall_mode_t stall_mode = STALL_NONE;

	function automatic scene_t predict_scene(tick_t t);
		logic [7:0]  low_fps, norm_fps, bright_rate, target, shown;
		logic [63:0] near_lhs, near_rhs, elapsed, dwell_us;
		logic        near, commit_ok;
		scene_t      r;
		low_fps     = cfg_fps_set[7:0];
		norm_fps    = cfg_fps_set[15:8];
		bright_rate = cfg_fps_set[23:16];
		r = '0;
		if (!(seen_eval_us != 0 && (t.now_us - seen_eval_us) < 64'(cfg_eval_ms) * 1000)) begin
			r.evaluated = 1'b1;
			seen_eval_us = t.now_us;
			if (t.ae_ok) begin
				if (norm_fps != 0) begin
					near_lhs = 64'(t.exposure) * 64'(norm_fps) * 64'd65536;
					near_rhs = 64'(cfg_low_ratio) * 64'd1000000;
					near = t.limit_hit || (t.exposure != 0 && near_lhs >= near_rhs);
					r.low_seen = near && t.gain >= cfg_gain_limits[31:16] &&
						t.luma <= cfg_luma_limits[31:16];
				end
				r.bright_seen = t.exposure != 0 && 24'(cfg_bright_max) >= t.exposure &&
					t.gain != 0 && t.gain <= cfg_gain_limits[15:0] &&
					t.luma >= cfg_luma_limits[15:0];
			end
			if (!t.ae_ok)
				target = norm_fps;
			else if (r.low_seen)
				target = low_fps;
			else if (r.bright_seen)
				target = bright_rate;
			else
				target = norm_fps;
			commit_ok = 1'b1;
			if (target != hold_rate) begin
				hold_rate = target;
				hold_since_us = t.now_us;
				commit_ok = 1'b0;
			end else if (target != locked_rate) begin
				if (target == bright_rate)
					dwell_us = 64'(cfg_confirm_ms[15:0]) * 1000;
				else if (target == low_fps)
					dwell_us = 64'(cfg_confirm_ms[31:16]) * 1000;
				else
					dwell_us = 64'(cfg_confirm_ms[47:32]) * 1000;
				if (t.now_us >= hold_since_us && t.now_us - hold_since_us < dwell_us)
					commit_ok = 1'b0;
			end
			if (commit_ok && target != locked_rate) begin
				elapsed = (switch_at_us != 0 && t.now_us >= switch_at_us) ?
					t.now_us - switch_at_us : '1;
				if (elapsed >= 64'(cfg_min_switch_ms) * 1000) begin
					locked_rate = target;
					switch_at_us = t.now_us;
					r.switched = 1'b1;
				end
			end
		end
		shown = (locked_rate != 0) ? locked_rate : norm_fps;
		r.fps = shown;
		r.cls = (shown == low_fps) ? CLASS_LOW : (shown == bright_rate) ? CLASS_BRIGHT : CLASS_NORMAL;
		return r;
	endfunction

	function automatic tick_t tick_of(logic [63:0] now, logic ok, logic hit, logic [23:0] expo,
			logic [15:0] gain, logic [15:0] luma);
		tick_t t;
		t.now_us    = now;
		t.ae_ok     = ok;
		t.limit_hit = hit;
		t.exposure  = expo;
		t.gain      = gain;
		t.luma      = luma;
		return t;
	endfunction

	function automatic tick_t make_fields(scene_kind_t kind);
		tick_t       t;
		logic [63:0] span, thr;
		logic [7:0]  norm;
		t.now_us    = '0;
		t.ae_ok     = 1'b1;
		t.limit_hit = 1'($urandom_range(1, 0));
		t.exposure  = 24'($urandom);
		t.gain      = 16'($urandom);
		t.luma      = 16'($urandom);
		norm = cfg_fps_set[15:8];
		case (kind)
			SCENE_LOW: begin
				if (norm != 0 && $urandom_range(1, 0) == 1) begin
					span = 64'(norm) * 64'd65536;
					thr = (64'(cfg_low_ratio) * 64'd1000000 + span - 1) / span;
					if (thr < 64'h00FF_FFF0)
						t.exposure = 24'(thr + $urandom_range(2, 0)) - 24'd1;
				end
				t.gain = 16'($urandom_range(16'hFFFF, cfg_gain_limits[31:16]));
				t.luma = 16'($urandom_range(cfg_luma_limits[31:16], 0));
			end
			SCENE_BRIGHT: begin
				t.limit_hit = ($urandom_range(3, 0) == 0);
				t.exposure  = 24'($urandom_range(cfg_bright_max, 1));
				t.gain      = 16'($urandom_range(cfg_gain_limits[15:0], 1));
				t.luma      = 16'($urandom_range(16'hFFFF, cfg_luma_limits[15:0]));
			end
			SCENE_PLAIN: begin
				t.limit_hit = 1'b0;
				t.exposure  = 24'($urandom_range(40000, 0));
			end
			SCENE_NOISE: t.ae_ok = 1'($urandom_range(1, 0));
			default: t.ae_ok = 1'b0;
		endcase
		return t;
	endfunction

	function automatic logic [63:0] next_time();
		int unsigned pick;
		pick = $urandom_range(99, 0);
		if (pick < 80)
			tick_clock_us = tick_clock_us + $urandom_range(step_max_us, 0);
		else if (pick < 86)
			tick_clock_us = tick_clock_us - $urandom_range(step_max_us, 0);
		else if (pick < 91)
			tick_clock_us = tick_clock_us;
		else if (pick < 95)
			tick_clock_us = {$urandom, $urandom};
		else if (pick < 98)
			tick_clock_us = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(20000, 0);
		else
			tick_clock_us = '0;
		return tick_clock_us;
	endfunction

	task automatic send_tick(tick_t t);
		tick_valid         <= 1'b1;
		now_us             <= t.now_us;
		ae_ok              <= t.ae_ok;
		exposure_limit_hit <= t.limit_hit;
		exposure_time      <= t.exposure;
		sensor_gain        <= t.gain;
		luma_avg           <= t.luma;
		@(posedge clk);
		while (tick_stall)
			@(posedge clk);
		expected_scene_q.push_back(predict_scene(t));
		@(negedge clk);
		if (steady_feed || burst_left > 0) begin
			if (burst_left > 0)
				burst_left--;
		end else begin
			tick_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
			burst_left = $urandom_range(20, 0);
		end
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		tick_valid <= 1'b0;
		while (expected_scene_q.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		case (idx)
			REG_FPS_SET:        cfg_fps_set       = value[23:0];
			REG_BRIGHT_MAX_EXP: cfg_bright_max    = value[19:0];
			REG_GAIN_LIMITS:    cfg_gain_limits   = value[31:0];
			REG_LUMA_LIMITS:    cfg_luma_limits   = value[31:0];
			REG_LOW_EXP_RATIO:  cfg_low_ratio     = value[15:0];
			REG_CONFIRM_TIMES:  cfg_confirm_ms    = value[47:0];
			REG_EVAL_INTERVAL:  cfg_eval_ms       = value[15:0];
			REG_MIN_SWITCH:     cfg_min_switch_ms = value[15:0];
			default: ;
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic load_settings(settings_style_t style);
		logic [23:0] fps;
		case (style)
			STYLE_ZERO: begin
				write_reg(REG_FPS_SET, '0);
				write_reg(REG_BRIGHT_MAX_EXP, '0);
				write_reg(REG_GAIN_LIMITS, '0);
				write_reg(REG_LUMA_LIMITS, '0);
				write_reg(REG_LOW_EXP_RATIO, '0);
				write_reg(REG_CONFIRM_TIMES, '0);
				write_reg(REG_EVAL_INTERVAL, '0);
				write_reg(REG_MIN_SWITCH, '0);
			end
			STYLE_MAX: begin
				write_reg(REG_FPS_SET, 48'hFF_FFFF);
				write_reg(REG_BRIGHT_MAX_EXP, 48'd1000000);
				write_reg(REG_GAIN_LIMITS, 48'hFFFF_FFFF);
				write_reg(REG_LUMA_LIMITS, 48'hFFFF_FFFF);
				write_reg(REG_LOW_EXP_RATIO, 48'hFFFF);
				write_reg(REG_CONFIRM_TIMES, 48'hFFFF_FFFF_FFFF);
				write_reg(REG_EVAL_INTERVAL, 48'hFFFF);
				write_reg(REG_MIN_SWITCH, 48'hFFFF);
			end
			default: begin
				fps = 24'($urandom);
				if ($urandom_range(3, 0) == 0)
					fps[23:16] = fps[7:0];
				if ($urandom_range(5, 0) == 0)
					fps[15:8] = fps[7:0];
				if ($urandom_range(7, 0) == 0)
					fps[15:8] = '0;
				write_reg(REG_FPS_SET, 48'(fps));
				write_reg(REG_BRIGHT_MAX_EXP, 48'($urandom_range(1000000, 0)));
				write_reg(REG_GAIN_LIMITS, 48'($urandom));
				write_reg(REG_LUMA_LIMITS, 48'($urandom));
				write_reg(REG_LOW_EXP_RATIO, 48'($urandom_range(16'hFFFF, 0)));
				write_reg(REG_CONFIRM_TIMES, {16'($urandom_range(8, 0)),
					16'($urandom_range(8, 0)), 16'($urandom_range(8, 0))});
				write_reg(REG_EVAL_INTERVAL, 48'($urandom_range(4, 0)));
				write_reg(REG_MIN_SWITCH, 48'($urandom_range(10, 0)));
			end
		endcase
		step_max_us = cfg_eval_ms * 2000 + 4000;
	endtask

	task automatic run_scenes(int unsigned count);
		int unsigned sent, pick, run;
		scene_kind_t kind;
		tick_t       t;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99, 0);
			if (pick < 30)
				kind = SCENE_LOW;
			else if (pick < 60)
				kind = SCENE_BRIGHT;
			else if (pick < 72)
				kind = SCENE_PLAIN;
			else if (pick < 85)
				kind = SCENE_NOISE;
			else
				kind = SCENE_BLIND;
			run = $urandom_range(10, 1);
			repeat (run) begin
				t = make_fields(kind);
				t.now_us = next_time();
				send_tick(t);
				sent++;
			end
		end
	endtask

	task automatic test_reset_defaults();
		send_tick(tick_of(64'd0, 1'b1, 1'b0, 24'd1000, 16'h0100, 16'h8000));
		send_tick(tick_of(64'd0, 1'b1, 1'b0, 24'd1000, 16'h0100, 16'h8000));
		send_tick(tick_of(64'd1_000_000, 1'b1, 1'b1, 24'd0, 16'h2000, 16'h1000));
		send_tick(tick_of(64'd1_400_000, 1'b1, 1'b1, 24'd0, 16'h2000, 16'h1000));
		send_tick(tick_of(64'd2_000_000, 1'b1, 1'b1, 24'd0, 16'h2000, 16'h1000));
		send_tick(tick_of(64'd3_000_000, 1'b1, 1'b0, 24'd10000, 16'h0200, 16'hEC00));
		send_tick(tick_of(64'd4_000_000, 1'b1, 1'b0, 24'd10000, 16'h0200, 16'hEC00));
		send_tick(tick_of(64'd7_000_000, 1'b1, 1'b0, 24'd10000, 16'h0200, 16'hEC00));
		send_tick(tick_of(64'd8_000_000, 1'b0, 1'b1, 24'hFF_FFFF, 16'hFFFF, 16'h0000));
	endtask

	task automatic test_field_extremes();
		send_tick(tick_of(64'd20_000_000, 1'b0, 1'b0, '0, '0, '0));
		send_tick(tick_of('1, 1'b1, 1'b1, '1, '1, '1));
		send_tick(tick_of(64'd30_000_000, 1'b1, 1'b0, 24'd27272, 16'h2000, 16'h1000));
		send_tick(tick_of(64'd31_000_000, 1'b1, 1'b0, 24'd27273, 16'h2000, 16'h1000));
	endtask

	task automatic test_time_going_back();
		write_reg(REG_CONFIRM_TIMES, {16'd20, 16'd20, 16'd20});
		send_tick(tick_of(64'd40_000_000, 1'b1, 1'b0, 24'd10000, 16'h0200, 16'hEC00));
		send_tick(tick_of(64'd39_000_000, 1'b1, 1'b0, 24'd10000, 16'h0200, 16'hEC00));
		send_tick(tick_of(64'd5_000_000, 1'b1, 1'b1, 24'd0, 16'h2000, 16'h1000));
		send_tick(tick_of(64'd4_000_000, 1'b1, 1'b1, 24'd0, 16'h2000, 16'h1000));
	endtask

	task automatic test_low_over_bright();
		write_reg(REG_GAIN_LIMITS, {16'h0100, 16'h0800});
		write_reg(REG_LUMA_LIMITS, {16'h8000, 16'h4000});
		send_tick(tick_of(64'd50_000_000, 1'b1, 1'b1, 24'd5000, 16'h0400, 16'h6000));
	endtask

	task automatic test_zero_normal_rate();
		write_reg(REG_FPS_SET, 48'h07_00_05);
		send_tick(tick_of(64'd60_000_000, 1'b1, 1'b1, '1, '1, '0));
		send_tick(tick_of(64'd70_000_000, 1'b1, 1'b1, '1, '1, '0));
		write_reg(REG_FPS_SET, 48'h09_09_09);
		send_tick(tick_of(64'd80_000_000, 1'b0, 1'b0, 24'd100, 16'h0100, 16'h0100));
	endtask

	task automatic test_random_scenes();
		tick_clock_us = 64'd100_000_000;
		for (int phase = 0; phase < 10; phase++) begin
			if (phase == 0)
				load_settings(STYLE_ZERO);
			else if (phase == 1)
				load_settings(STYLE_MAX);
			else
				load_settings(STYLE_TIGHT);
			run_scenes(200);
		end
	endtask

	task automatic test_back_pressure();
		load_settings(STYLE_TIGHT);
		steady_feed  = 1'b1;
		hold_request = 300;
		run_scenes(60);
		steady_feed = 1'b0;
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_field_extremes();
		test_time_going_back();
		test_low_over_bright();
		test_zero_normal_rate();
		test_random_scenes();
		test_back_pressure();
		tick_valid <= 1'b0;
		while (expected_scene_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(STALL_HEAVY, STALL_NONE));
				mode_left = $urandom_range(150, 20);
			end
			mode_left--;
			case (stall_mode)
				STALL_NONE:  result_stall <= 1'b0;
				STALL_LIGHT: result_stall <= ($urandom_range(3, 0) == 0);
				default:     result_stall <= ($urandom_range(9, 0) < 7);
			endcase
		end
	end

	always @(posedge clk) begin : check_results
		scene_t got, want;
		if (arst_n && result_valid && !result_stall) begin
			got.fps         = frame_rate;
			got.cls         = scene_class_t'(scene_class);
			got.evaluated   = evaluated;
			got.low_seen    = low_light_seen;
			got.bright_seen = bright_seen;
			got.switched    = switched;
			if (expected_scene_q.size() == 0) begin
				$display("%0t: result beat with no tick waiting: fps %0d class %0d eval %b low %b bright %b sw %b",
					$time, got.fps, got.cls, got.evaluated, got.low_seen, got.bright_seen,
					got.switched);
				fail_count++;
			end else begin
				want = expected_scene_q.pop_front();
				if (got !== want) begin
					$display("%0t: scene mismatch expected fps %0d class %0d eval %b low %b bright %b sw %b",
						$time, want.fps, want.cls, want.evaluated, want.low_seen,
						want.bright_seen, want.switched);
					$display("%0t:                actual fps %0d class %0d eval %b low %b bright %b sw %b",
						$time, got.fps, got.cls, got.evaluated, got.low_seen,
						got.bright_seen, got.switched);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/lsfps_pkg.sv
rtl/lsfps_front.sv
rtl/lsfps_queue.sv
rtl/lsfps_back.sv
rtl/light_scene_fps_selector_unit.sv
rtl/lsfps_checker.sv
bench/light_scene_fps_selector_unit_test.sv
